@@ src/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg
// shared types and constants for the midi track event parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam logic [23:0] TEMPO_RESET = 24'd500000;

  localparam logic [7:0] STATUS_BIT   = 8'h80;
  localparam logic [7:0] DATA_MASK    = 8'h7f;
  localparam logic [7:0] HI_MASK      = 8'hf0;
  localparam logic [7:0] STATUS_META  = 8'hff;
  localparam logic [7:0] META_EOT     = 8'h2f;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] HI_PROG      = 8'hc0;
  localparam logic [7:0] HI_CHPRESS   = 8'hd0;
  localparam logic [7:0] HI_SYSTEM    = 8'hf0;
  localparam logic [7:0] NO_STATUS    = 8'h00;

  typedef enum logic [2:0] {
    KIND_CHAN2  = 3'd0,
    KIND_CHAN1  = 3'd1,
    KIND_SYSEX  = 3'd2,
    KIND_META   = 3'd3,
    KIND_TEMPO  = 3'd4,
    KIND_EOT    = 3'd5,
    KIND_ERROR  = 3'd6
  } event_kind_e;

  typedef struct packed {
    logic        valid;
    event_kind_e kind;
    logic [7:0]  status;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [7:0]  meta_kind;
    logic [31:0] delta_ticks;
    logic [23:0] tempo_us;
  } result_t;

endpackage

`default_nettype wire

@@ src/mtep_core.sv @@
// ----------------------------------------------------------------------------
// mtep_core
// parser state and per-byte decode, one byte per enabled cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtep_core #(
  parameter int unsigned COUNT_WIDTH = mtep_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  output mtep_pkg::result_t     res_o
);
  import mtep_pkg::*;

  typedef enum logic [3:0] {
    PH_DELTA_START = 4'd0,
    PH_DELTA_MORE  = 4'd1,
    PH_STATUS      = 4'd2,
    PH_DATA1       = 4'd3,
    PH_DATA2       = 4'd4,
    PH_DATA_ONE    = 4'd5,
    PH_META_TYPE   = 4'd6,
    PH_LEN         = 4'd7,
    PH_BODY        = 4'd8
  } phase_e;

  localparam logic [COUNT_WIDTH-1:0] LEN_ZERO  = '0;
  localparam logic [COUNT_WIDTH-1:0] LEN_ONE   = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] LEN_TEMPO = COUNT_WIDTH'(3);

  phase_e                 phase_q, phase_d;
  logic [7:0]             run_q, run_d;
  logic [7:0]             cur_q, cur_d;
  logic [31:0]            delta_q, delta_d;
  logic [COUNT_WIDTH-1:0] len_q, len_d;
  logic [COUNT_WIDTH-1:0] len_base;
  logic [7:0]             held_d1_q, held_d1_d;
  logic [7:0]             held_mk_q, held_mk_d;
  logic [23:0]            tempo_q, tempo_d;
  logic [23:0]            shift_q, shift_d;
  logic                   fin_q, fin_d;

  logic                   explicit_st;
  logic [7:0]             st_v;
  logic                   do_len;
  logic                   do_fin;
  logic                   do_err;
  result_t                res;

  always_comb begin
    phase_d   = phase_q;
    run_d     = run_q;
    cur_d     = cur_q;
    delta_d   = delta_q;
    len_d     = len_q;
    held_d1_d = held_d1_q;
    held_mk_d = held_mk_q;
    tempo_d   = tempo_q;
    shift_d   = shift_q;
    fin_d     = fin_q;
    len_base  = len_q;
    do_len    = 1'b0;
    do_fin    = 1'b0;
    do_err    = 1'b0;
    explicit_st = (data_byte_i & STATUS_BIT) != 8'h00;
    st_v      = cur_q;
    res       = '0;
    res.kind  = KIND_CHAN2;

    if (!fin_q) begin
      case (phase_q)
        PH_DELTA_START: begin
          delta_d = {25'd0, data_byte_i[6:0]};
          phase_d = explicit_st ? PH_DELTA_MORE : PH_STATUS;
        end
        PH_DELTA_MORE: begin
          delta_d = {delta_q[24:0], data_byte_i[6:0]};
          if (!explicit_st) begin
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (explicit_st) begin
            run_d = data_byte_i;
            st_v  = data_byte_i;
          end else begin
            st_v  = run_q;
          end
          if (!explicit_st && run_q == NO_STATUS) begin
            do_err = 1'b1;
          end else begin
            cur_d = st_v;
            if ((st_v & HI_MASK) == HI_PROG || (st_v & HI_MASK) == HI_CHPRESS) begin
              if (explicit_st) begin
                phase_d = PH_DATA_ONE;
              end else begin
                phase_d        = PH_DELTA_START;
                res.valid      = 1'b1;
                res.kind       = KIND_CHAN1;
                res.status     = st_v;
                res.first_data = data_byte_i;
              end
            end else if ((st_v & HI_MASK) == HI_SYSTEM) begin
              len_d    = LEN_ZERO;
              len_base = LEN_ZERO;
              if (st_v == STATUS_META) begin
                if (explicit_st) begin
                  phase_d = PH_META_TYPE;
                end else begin
                  held_mk_d = data_byte_i;
                  phase_d   = PH_LEN;
                end
              end else begin
                phase_d = PH_LEN;
                do_len  = !explicit_st;
              end
            end else begin
              if (explicit_st) begin
                phase_d = PH_DATA1;
              end else begin
                held_d1_d = data_byte_i;
                phase_d   = PH_DATA2;
              end
            end
          end
        end
        PH_DATA1: begin
          held_d1_d = data_byte_i;
          phase_d   = PH_DATA2;
        end
        PH_DATA2: begin
          phase_d         = PH_DELTA_START;
          res.valid       = 1'b1;
          res.kind        = KIND_CHAN2;
          res.status      = cur_q;
          res.first_data  = held_d1_q;
          res.second_data = data_byte_i;
        end
        PH_DATA_ONE: begin
          phase_d        = PH_DELTA_START;
          res.valid      = 1'b1;
          res.kind       = KIND_CHAN1;
          res.status     = cur_q;
          res.first_data = data_byte_i;
        end
        PH_META_TYPE: begin
          held_mk_d = data_byte_i;
          len_d     = LEN_ZERO;
          phase_d   = PH_LEN;
        end
        PH_LEN: begin
          do_len = 1'b1;
        end
        PH_BODY: begin
          if (held_mk_q == META_TEMPO && cur_q == STATUS_META) begin
            shift_d = {shift_q[15:0], data_byte_i};
          end
          len_d = len_q - LEN_ONE;
          if (len_d == LEN_ZERO) begin
            do_fin = 1'b1;
          end
        end
        default: begin
          phase_d = PH_DELTA_START;
        end
      endcase
    end

    // length byte
    if (do_len) begin
      len_d = {len_base[COUNT_WIDTH-8:0], data_byte_i[6:0]};
      if (!explicit_st) begin
        shift_d = '0;
        if (cur_d == STATUS_META && held_mk_d == META_TEMPO && len_d != LEN_TEMPO) begin
          do_err = 1'b1;
        end else if (len_d == LEN_ZERO) begin
          do_fin = 1'b1;
        end else begin
          phase_d = PH_BODY;
        end
      end
    end

    // end of a sysex or meta body
    if (do_fin) begin
      phase_d   = PH_DELTA_START;
      res.valid = 1'b1;
      if (cur_d != STATUS_META) begin
        res.kind   = KIND_SYSEX;
        res.status = cur_d;
      end else if (held_mk_d == META_EOT) begin
        fin_d         = 1'b1;
        res.kind      = KIND_EOT;
        res.status    = STATUS_META;
        res.meta_kind = META_EOT;
      end else if (held_mk_d == META_TEMPO) begin
        tempo_d       = shift_d;
        res.kind      = KIND_TEMPO;
        res.status    = STATUS_META;
        res.meta_kind = META_TEMPO;
      end else begin
        res.kind      = KIND_META;
        res.status    = STATUS_META;
        res.meta_kind = held_mk_d;
      end
    end

    // chunk ends mid-event
    if (last_byte_i && !res.valid && !do_err && !fin_d && phase_d != PH_DELTA_START) begin
      do_err = 1'b1;
    end

    if (do_err) begin
      fin_d           = 1'b1;
      res             = '0;
      res.valid       = 1'b1;
      res.kind        = KIND_ERROR;
      res.status      = cur_d;
    end

    res.delta_ticks = delta_d;
    res.tempo_us    = tempo_d;

    if (last_byte_i) begin
      phase_d   = PH_DELTA_START;
      run_d     = NO_STATUS;
      cur_d     = NO_STATUS;
      delta_d   = '0;
      len_d     = LEN_ZERO;
      held_d1_d = '0;
      held_mk_d = '0;
      shift_d   = '0;
      fin_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_DELTA_START;
      run_q     <= NO_STATUS;
      cur_q     <= NO_STATUS;
      delta_q   <= '0;
      len_q     <= LEN_ZERO;
      held_d1_q <= '0;
      held_mk_q <= '0;
      tempo_q   <= TEMPO_RESET;
      shift_q   <= '0;
      fin_q     <= 1'b0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      run_q     <= run_d;
      cur_q     <= cur_d;
      delta_q   <= delta_d;
      len_q     <= len_d;
      held_d1_q <= held_d1_d;
      held_mk_q <= held_mk_d;
      tempo_q   <= tempo_d;
      shift_q   <= shift_d;
      fin_q     <= fin_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

@@ src/midi_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_parser
// decodes the events of one standard midi file track chunk, while not stalled, one byte per cycle
// ----------------------------------------------------------------------------
// output: the result is registered and is valid in the cycle after the byte that ends
//   the event (or the error) is accepted
// throughput: one byte per cycle while in_stall_o is low; input stalls while a held result sees out_stall_i
// reset: parser waits for a delta time, no running status, tempo 500000 us
`timescale 1ns / 1ps
`default_nettype none

module midi_track_event_parser #(
  parameter int unsigned COUNT_WIDTH = mtep_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_kind_o,
  output logic [7:0]       status_byte_o,
  output logic [7:0]       first_data_o,
  output logic [7:0]       second_data_o,
  output logic [7:0]       meta_kind_o,
  output logic [31:0]      delta_ticks_o,
  output logic [23:0]      tempo_us_o
);
  import mtep_pkg::*;

  logic    in_accept;
  result_t res;
  result_t out_q;
  logic    out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  mtep_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (in_accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = res.valid;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = out_q.kind;
  assign status_byte_o = out_q.status;
  assign first_data_o  = out_q.first_data;
  assign second_data_o = out_q.second_data;
  assign meta_kind_o   = out_q.meta_kind;
  assign delta_ticks_o = out_q.delta_ticks;
  assign tempo_us_o    = out_q.tempo_us;

endmodule

`default_nettype wire
